FILE: hw/rtl/fixed_point_alu_q24_8_assert.svh
// Assertion macros used by the checker file.
`ifndef FIXED_POINT_ALU_Q24_8_ASSERT_SVH
`define FIXED_POINT_ALU_Q24_8_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define FPA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpa assertion failed");

// Next-cycle implication, quiet during reset.
`define FPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpa assertion failed");

`endif

FILE: hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Opcodes, result types and saturation helper for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam logic [3:0] OP_ADD      = 4'd0;
   localparam logic [3:0] OP_SUB      = 4'd1;
   localparam logic [3:0] OP_MUL      = 4'd2;
   localparam logic [3:0] OP_DIV      = 4'd3;
   localparam logic [3:0] OP_GT       = 4'd4;
   localparam logic [3:0] OP_LT       = 4'd5;
   localparam logic [3:0] OP_GE       = 4'd6;
   localparam logic [3:0] OP_LE       = 4'd7;
   localparam logic [3:0] OP_EQ       = 4'd8;
   localparam logic [3:0] OP_NE       = 4'd9;
   localparam logic [3:0] OP_MIN      = 4'd10;
   localparam logic [3:0] OP_MAX      = 4'd11;
   localparam logic [3:0] OP_INC      = 4'd12;
   localparam logic [3:0] OP_DEC      = 4'd13;
   localparam logic [3:0] OP_TO_INT   = 4'd14;
   localparam logic [3:0] OP_FROM_INT = 4'd15;

   localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] value;
      logic        ovf;
   } sat_type;

   typedef struct packed {
      logic [31:0] result;
      logic        truth;
      logic        ovf;
      logic        dz;
   } res_type;

   function automatic sat_type sat64(input logic signed [63:0] v);
      sat_type s;
      s.value = v[31:0];
      s.ovf   = 1'b0;
      if (v > 64'sd2147483647) begin
         s.value = S32_MAX;
         s.ovf   = 1'b1;
      end else if (v < -64'sd2147483648) begin
         s.value = S32_MIN;
         s.ovf   = 1'b1;
      end
      return s;
   endfunction

endpackage

FILE: hw/rtl/fpa_delay.sv
// ----------------------------------------------------------------------------
// fpa_delay
// Enabled shift line that keeps side results aligned with the divider.
// ----------------------------------------------------------------------------
module fpa_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

FILE: hw/rtl/fpa_mul.sv
// ----------------------------------------------------------------------------
// fpa_mul
// Two-stage multiply: full product, then scale toward zero and saturate.
// ----------------------------------------------------------------------------
module fpa_mul #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [31:0]  a,
   input  logic signed [31:0]  b,
   output fpa_pkg::sat_type    dout
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] adj;
   fpa_pkg::sat_type   sat_ff;

   always_comb begin
      adj = prod_ff;
      if (prod_ff[63]) begin
         adj = prod_ff + ((64'sd1 <<< FRACTION_BITS) - 64'sd1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= 64'(a) * 64'(b);
         sat_ff  <= fpa_pkg::sat64(adj >>> FRACTION_BITS);
      end
   end

   assign dout = sat_ff;

endmodule

FILE: hw/rtl/fpa_div.sv
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, signed fixup last.
// ----------------------------------------------------------------------------
module fpa_div #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [31:0]  a,
   input  logic signed [31:0]  b,
   output fpa_pkg::res_type    dout
);

   localparam int DW = 32 + FRACTION_BITS;

   logic [31:0]   rem_ff  [DW];
   logic [DW-1:0] dvd_ff  [DW];
   logic [DW-1:0] quo_ff  [DW];
   logic [31:0]   dsr_ff  [DW];
   logic          neg_ff  [DW];
   logic          asgn_ff [DW];
   logic          dz_ff   [DW];

   logic [31:0]   a_mag;
   logic [31:0]   b_mag;
   fpa_pkg::res_type out_ff;
   logic [DW-1:0] q;
   logic [63:0]   q_ext;

   assign a_mag = a[31] ? 32'(-a) : 32'(a);
   assign b_mag = b[31] ? 32'(-b) : 32'(b);

   for (genvar i = 0; i < DW; i++) begin : g_stage
      logic [31:0]   rem_in;
      logic [DW-1:0] dvd_in;
      logic [DW-1:0] quo_in;
      logic [31:0]   dsr_in;
      logic          neg_in;
      logic          asgn_in;
      logic          dz_in;
      logic [32:0]   trial;
      logic          fit;

      if (i == 0) begin : g_head
         assign rem_in  = '0;
         assign dvd_in  = DW'(a_mag) << FRACTION_BITS;
         assign quo_in  = '0;
         assign dsr_in  = b_mag;
         assign neg_in  = a[31] ^ b[31];
         assign asgn_in = a[31];
         assign dz_in   = (b == 32'sd0);
      end else begin : g_body
         assign rem_in  = rem_ff[i-1];
         assign dvd_in  = dvd_ff[i-1];
         assign quo_in  = quo_ff[i-1];
         assign dsr_in  = dsr_ff[i-1];
         assign neg_in  = neg_ff[i-1];
         assign asgn_in = asgn_ff[i-1];
         assign dz_in   = dz_ff[i-1];
      end

      assign trial = {rem_in, dvd_in[DW-1]};
      assign fit   = trial >= {1'b0, dsr_in};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= fit ? 32'(trial - {1'b0, dsr_in}) : trial[31:0];
            dvd_ff[i]  <= dvd_in << 1;
            quo_ff[i]  <= {quo_in[DW-2:0], fit};
            dsr_ff[i]  <= dsr_in;
            neg_ff[i]  <= neg_in;
            asgn_ff[i] <= asgn_in;
            dz_ff[i]   <= dz_in;
         end
      end
   end

   assign q     = quo_ff[DW-1];
   assign q_ext = 64'(q);

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.truth <= 1'b0;
         out_ff.dz    <= dz_ff[DW-1];
         if (dz_ff[DW-1]) begin
            out_ff.result <= asgn_ff[DW-1] ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
            out_ff.ovf    <= 1'b0;
         end else if (neg_ff[DW-1]) begin
            if (q_ext > 64'h8000_0000) begin
               out_ff.result <= fpa_pkg::S32_MIN;
               out_ff.ovf    <= 1'b1;
            end else begin
               out_ff.result <= 32'(-q[31:0]);
               out_ff.ovf    <= 1'b0;
            end
         end else begin
            if (q_ext > 64'h7fff_ffff) begin
               out_ff.result <= fpa_pkg::S32_MAX;
               out_ff.ovf    <= 1'b1;
            end else begin
               out_ff.result <= q[31:0];
               out_ff.ovf    <= 1'b0;
            end
         end
      end
   end

   assign dout = out_ff;

endmodule

FILE: hw/rtl/fixed_point_alu_q24_8.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Saturating signed fixed-point ALU, 32-bit raw values, pipelined throughout.
// ----------------------------------------------------------------------------
//   channel   dir   handshake          payload
//   req       in    req_valid/stall    kind, operand_a, operand_b
//   rsp       out   rsp_valid/stall    result, truth, overflow, divide_by_zero
//
// One request per cycle while the response is not stalled; the depth is set by the
// divider, which resolves one quotient bit per stage.
// All stages advance together; a stalled response freezes the whole pipe.
// Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
   parameter int FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_kind,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result,
   output logic               rsp_truth,
   output logic               rsp_overflow,
   output logic               rsp_divide_by_zero
);

   localparam int LD = 33 + FRACTION_BITS;

   logic               adv;
   logic               s1_vld_ff;
   logic [3:0]         s1_kind_ff;
   logic signed [31:0] s1_a_ff;
   logic signed [31:0] s1_b_ff;
   logic [LD-1:0]      vld_ff;
   logic               rsp_vld_ff;
   fpa_pkg::res_type   rsp_ff;

   fpa_pkg::res_type   simple;
   fpa_pkg::res_type   simple_d;
   fpa_pkg::sat_type   mul_out;
   fpa_pkg::sat_type   mul_d;
   fpa_pkg::res_type   div_out;
   logic [3:0]         kind_d;
   fpa_pkg::res_type   sel;
   logic signed [63:0] a64;
   logic signed [63:0] b64;
   logic signed [63:0] toint;

   assign adv       = !rsp_vld_ff || !rsp_stall;
   assign req_stall = !adv;

   assign a64   = 64'(s1_a_ff);
   assign b64   = 64'(s1_b_ff);
   assign toint = (a64 + (s1_a_ff[31] ? ((64'sd1 <<< FRACTION_BITS) - 64'sd1) : 64'sd0))
                  >>> FRACTION_BITS;

   always_comb begin
      fpa_pkg::sat_type s;
      s             = '0;
      simple        = '0;
      case (s1_kind_ff)
         fpa_pkg::OP_ADD:      s = fpa_pkg::sat64(a64 + b64);
         fpa_pkg::OP_SUB:      s = fpa_pkg::sat64(a64 - b64);
         fpa_pkg::OP_INC:      s = fpa_pkg::sat64(a64 + 64'sd1);
         fpa_pkg::OP_DEC:      s = fpa_pkg::sat64(a64 - 64'sd1);
         fpa_pkg::OP_FROM_INT: s = fpa_pkg::sat64(a64 <<< FRACTION_BITS);
         fpa_pkg::OP_TO_INT:   s.value = toint[31:0];
         fpa_pkg::OP_MIN:      s.value = (s1_a_ff <= s1_b_ff) ? s1_a_ff : s1_b_ff;
         fpa_pkg::OP_MAX:      s.value = (s1_a_ff >= s1_b_ff) ? s1_a_ff : s1_b_ff;
         fpa_pkg::OP_GT:       simple.truth = s1_a_ff > s1_b_ff;
         fpa_pkg::OP_LT:       simple.truth = s1_a_ff < s1_b_ff;
         fpa_pkg::OP_GE:       simple.truth = s1_a_ff >= s1_b_ff;
         fpa_pkg::OP_LE:       simple.truth = s1_a_ff <= s1_b_ff;
         fpa_pkg::OP_EQ:       simple.truth = s1_a_ff == s1_b_ff;
         fpa_pkg::OP_NE:       simple.truth = s1_a_ff != s1_b_ff;
         default:              s = '0;
      endcase
      simple.result = s.value;
      simple.ovf    = s.ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= req_valid;
         vld_ff     <= {vld_ff[LD-2:0], s1_vld_ff};
         rsp_vld_ff <= vld_ff[LD-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff <= req_kind;
         s1_a_ff    <= req_operand_a;
         s1_b_ff    <= req_operand_b;
         rsp_ff     <= sel;
      end
   end

   fpa_delay #(.WIDTH($bits(fpa_pkg::res_type)), .DEPTH(LD)) u_simple_dly (
      .clock (clock),
      .en    (adv),
      .din   (simple),
      .dout  (simple_d)
   );

   fpa_delay #(.WIDTH(4), .DEPTH(LD)) u_kind_dly (
      .clock (clock),
      .en    (adv),
      .din   (s1_kind_ff),
      .dout  (kind_d)
   );

   fpa_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock (clock),
      .en    (adv),
      .a     (s1_a_ff),
      .b     (s1_b_ff),
      .dout  (mul_out)
   );

   fpa_delay #(.WIDTH($bits(fpa_pkg::sat_type)), .DEPTH(LD-2)) u_mul_dly (
      .clock (clock),
      .en    (adv),
      .din   (mul_out),
      .dout  (mul_d)
   );

   fpa_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock (clock),
      .en    (adv),
      .a     (s1_a_ff),
      .b     (s1_b_ff),
      .dout  (div_out)
   );

   always_comb begin
      case (kind_d)
         fpa_pkg::OP_MUL: begin
            sel        = '0;
            sel.result = mul_d.value;
            sel.ovf    = mul_d.ovf;
         end
         fpa_pkg::OP_DIV: sel = div_out;
         default:         sel = simple_d;
      endcase
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_result         = rsp_ff.result;
   assign rsp_truth          = rsp_ff.truth;
   assign rsp_overflow       = rsp_ff.ovf;
   assign rsp_divide_by_zero = rsp_ff.dz;

endmodule

FILE: hw/rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the fixed-point ALU response channel.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_q24_8_assert.svh"

module fpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result,
   input logic        rsp_truth,
   input logic        rsp_overflow,
   input logic        rsp_divide_by_zero
);

   logic at_rail;
   logic any_flag;

   assign at_rail  = (rsp_result == fpa_pkg::S32_MAX) || (rsp_result == fpa_pkg::S32_MIN);
   assign any_flag = rsp_overflow || rsp_divide_by_zero;

   `FPA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result))
   `FPA_ASSERT_IMPLY(a_flags, clock, reset, rsp_valid, !(rsp_truth && any_flag))
   `FPA_ASSERT_IMPLY(a_dz_sat, clock, reset, rsp_valid && rsp_divide_by_zero, !rsp_overflow && at_rail)
   `FPA_ASSERT_IMPLY(a_ovf_sat, clock, reset, rsp_valid && rsp_overflow, at_rail)

endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result         (rsp_result),
   .rsp_truth          (rsp_truth),
   .rsp_overflow       (rsp_overflow),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the saturating Q24.8 ALU: directed corner operands for every opcode,
// then random requests with random gaps and response stalls, each response
// compared field by field against an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int FRAC        = 8;
   localparam int WATCH_LIMIT = 4000;

   typedef struct packed {
      logic [31:0] result;
      logic        truth;
      logic        ovf;
      logic        dz;
   } alu_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [3:0]         req_kind = fpa_pkg::OP_ADD;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result;
   logic               rsp_truth;
   logic               rsp_overflow;
   logic               rsp_divide_by_zero;

   alu_out_type expected_q[$];
   int          errors = 0;
   bit          no_gaps = 1'b0;
   int          idle_count = 0;
   int          rsp_wait = 0;

   fixed_point_alu_q24_8 #(.FRACTION_BITS(FRAC)) dut (.*);

   always #10 clock = ~clock;

   function automatic logic [31:0] clip(input logic signed [63:0] v, inout logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return fpa_pkg::S32_MAX;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return fpa_pkg::S32_MIN;
      end
      return v[31:0];
   endfunction

   function automatic alu_out_type alu_predict(input logic [3:0] k,
                                               input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      alu_out_type o;
      logic signed [63:0] wa, wb, scale;
      o = '0;
      wa = a;
      wb = b;
      scale = 64'sd1 << FRAC;
      case (k)
         fpa_pkg::OP_ADD: o.result = clip(wa + wb, o.ovf);
         fpa_pkg::OP_SUB: o.result = clip(wa - wb, o.ovf);
         fpa_pkg::OP_MUL: o.result = clip((wa * wb) / scale, o.ovf);
         fpa_pkg::OP_DIV: begin
            if (b == 0) begin
               o.dz = 1'b1;
               o.result = (a < 0) ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
            end else begin
               o.result = clip((wa * scale) / wb, o.ovf);
            end
         end
         fpa_pkg::OP_GT: o.truth = a > b;
         fpa_pkg::OP_LT: o.truth = a < b;
         fpa_pkg::OP_GE: o.truth = a >= b;
         fpa_pkg::OP_LE: o.truth = a <= b;
         fpa_pkg::OP_EQ: o.truth = a == b;
         fpa_pkg::OP_NE: o.truth = a != b;
         fpa_pkg::OP_MIN: o.result = (a <= b) ? a : b;
         fpa_pkg::OP_MAX: o.result = (a >= b) ? a : b;
         fpa_pkg::OP_INC: o.result = clip(wa + 1, o.ovf);
         fpa_pkg::OP_DEC: o.result = clip(wa - 1, o.ovf);
         fpa_pkg::OP_TO_INT: o.result = 32'(wa / scale);
         default: o.result = clip(wa * scale, o.ovf);
      endcase
      return o;
   endfunction

   task automatic send_request(input logic [3:0] k, input logic signed [31:0] a,
                               input logic signed [31:0] b);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(alu_predict(k, a, b));
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(7))
         0: return fpa_pkg::S32_MAX;
         1: return fpa_pkg::S32_MIN;
         2: return 32'($signed($urandom_range(2047)) - 1024);
         3: return $urandom_range(1) ? 32'sd0 : 32'sd256;
         4: return 32'($signed($urandom_range(131071)) - 65536);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] corner[6];
      corner = '{fpa_pkg::S32_MAX, fpa_pkg::S32_MIN, 32'd0, 32'd256, 32'hffff_ff00, 32'd1};
      for (int k = 0; k < 16; k++)
         send_request(4'(k), corner[k % 6], corner[(k + 1) % 6]);
      send_request(fpa_pkg::OP_DIV, 32'd5, 32'd0);
      send_request(fpa_pkg::OP_DIV, 32'hffff_fffb, 32'd0);
      send_request(fpa_pkg::OP_DIV, fpa_pkg::S32_MIN, 32'hffff_ffff);
      send_request(fpa_pkg::OP_MUL, fpa_pkg::S32_MIN, fpa_pkg::S32_MIN);
      send_request(fpa_pkg::OP_MIN, 32'd7, 32'd7);
      send_request(fpa_pkg::OP_TO_INT, 32'hffff_ff01, 32'd0);
      send_request(fpa_pkg::OP_EQ, 32'd3, 32'd3);
      go_idle();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         no_gaps = (i % 400) < 100;
         send_request(4'($urandom_range(15)), rand_operand(),
                      ($urandom_range(3) == 0) ? 32'sd0 : rand_operand());
      end
      no_gaps = 1'b0;
      go_idle();
   endtask

   // response stall: a wait drawn at random per response, none during no-gap runs
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      alu_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_wait = no_gaps ? 0 : $urandom_range(15);
         if (expected_q.size() == 0) begin
            $error("unexpected response result=%h", rsp_result);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_result !== want.result) begin
               $error("result exp %h got %h", want.result, rsp_result);
               errors++;
            end
            if (rsp_truth !== want.truth) begin
               $error("truth exp %b got %b", want.truth, rsp_truth);
               errors++;
            end
            if (rsp_overflow !== want.ovf) begin
               $error("overflow exp %b got %b", want.ovf, rsp_overflow);
               errors++;
            end
            if (rsp_divide_by_zero !== want.dz) begin
               $error("divide_by_zero exp %b got %b", want.dz, rsp_divide_by_zero);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCH_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1600);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_delay.sv
hw/rtl/fpa_mul.sv
hw/rtl/fpa_div.sv
hw/rtl/fixed_point_alu_q24_8.sv
hw/rtl/fpa_checker.sv
tb/tb_top.sv
